// ===== hw/rtl/cabac_binary_arithmetic_encoder_macros.svh =====
// Assertion helpers used by the encoder back end.
`ifndef CABAC_BINARY_ARITHMETIC_ENCODER_MACROS_SVH
`define CABAC_BINARY_ARITHMETIC_ENCODER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CABAC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define CABAC_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/cabac_pkg.sv =====
package cabac_pkg;

  localparam int NUM_CONTEXTS = 1024;
  localparam int CTX_AW       = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int OUT_W        = 16;
  localparam int IDX_W        = 10;
  localparam int LOW_W        = 10;
  localparam int RNG_W        = 9;
  localparam int ST_W         = 6;
  localparam int CTX_W        = 7;
  localparam int FOLLOW_W     = 16;
  localparam int FIFO_DEPTH   = 2;

  localparam logic [OUT_W-1:0] OUT_MAX      = {OUT_W{1'b1}};
  localparam logic [32:0]      OUT_MAX_WIDE = (33'd1 << OUT_W) - 33'd1;
  localparam logic [32:0]      FOLLOW_MAX   = 33'd65535;

  typedef enum logic [1:0] {
    CMD_REGULAR    = 2'd0,
    CMD_TERMINATE  = 2'd1,
    CMD_LOAD_CTX   = 2'd2,
    CMD_LOAD_CODER = 2'd3
  } cmd_e;

  // Classified command as it travels from front to back.
  typedef struct packed {
    cmd_e              cmd;
    logic              bin;
    logic              idx_ok;
    logic [CTX_AW-1:0] idx;
    logic [CTX_W-1:0]  ctx;
    logic [LOW_W-1:0]  low;
    logic [RNG_W-1:0]  rng;
    logic [OUT_W-1:0]  outs;
    logic              outs_sat;
  } item_t;

  typedef struct packed {
    logic                bit_v;
    logic [FOLLOW_W-1:0] follow;
    logic                ov;
  } run_t;

  typedef struct packed {
    run_t run;
    logic last;
  } out_t;

  localparam logic [7:0] LPS_TAB [64][4] = '{
    '{8'd128,8'd176,8'd208,8'd240}, '{8'd128,8'd167,8'd197,8'd227},
    '{8'd128,8'd158,8'd187,8'd216}, '{8'd123,8'd150,8'd178,8'd205},
    '{8'd116,8'd142,8'd169,8'd195}, '{8'd111,8'd135,8'd160,8'd185},
    '{8'd105,8'd128,8'd152,8'd175}, '{8'd100,8'd122,8'd144,8'd166},
    '{8'd95,8'd116,8'd137,8'd158},  '{8'd90,8'd110,8'd130,8'd150},
    '{8'd85,8'd104,8'd123,8'd142},  '{8'd81,8'd99,8'd117,8'd135},
    '{8'd77,8'd94,8'd111,8'd128},   '{8'd73,8'd89,8'd105,8'd122},
    '{8'd69,8'd85,8'd100,8'd116},   '{8'd66,8'd80,8'd95,8'd110},
    '{8'd62,8'd76,8'd90,8'd104},    '{8'd59,8'd72,8'd86,8'd99},
    '{8'd56,8'd69,8'd81,8'd94},     '{8'd53,8'd65,8'd77,8'd89},
    '{8'd51,8'd62,8'd73,8'd85},     '{8'd48,8'd59,8'd69,8'd80},
    '{8'd46,8'd56,8'd66,8'd76},     '{8'd43,8'd53,8'd63,8'd72},
    '{8'd41,8'd50,8'd59,8'd69},     '{8'd39,8'd48,8'd56,8'd65},
    '{8'd37,8'd45,8'd54,8'd62},     '{8'd35,8'd43,8'd51,8'd59},
    '{8'd33,8'd41,8'd48,8'd56},     '{8'd32,8'd39,8'd46,8'd53},
    '{8'd30,8'd37,8'd43,8'd50},     '{8'd29,8'd35,8'd41,8'd48},
    '{8'd27,8'd33,8'd39,8'd45},     '{8'd26,8'd31,8'd37,8'd43},
    '{8'd24,8'd30,8'd35,8'd41},     '{8'd23,8'd28,8'd33,8'd39},
    '{8'd22,8'd27,8'd32,8'd37},     '{8'd21,8'd26,8'd30,8'd35},
    '{8'd20,8'd24,8'd29,8'd33},     '{8'd19,8'd23,8'd27,8'd31},
    '{8'd18,8'd22,8'd26,8'd30},     '{8'd17,8'd21,8'd25,8'd28},
    '{8'd16,8'd20,8'd23,8'd27},     '{8'd15,8'd19,8'd22,8'd25},
    '{8'd14,8'd18,8'd21,8'd24},     '{8'd14,8'd17,8'd20,8'd23},
    '{8'd13,8'd16,8'd19,8'd22},     '{8'd12,8'd15,8'd18,8'd21},
    '{8'd12,8'd14,8'd17,8'd20},     '{8'd11,8'd14,8'd16,8'd19},
    '{8'd11,8'd13,8'd15,8'd18},     '{8'd10,8'd12,8'd15,8'd17},
    '{8'd10,8'd12,8'd14,8'd16},     '{8'd9,8'd11,8'd13,8'd15},
    '{8'd9,8'd11,8'd12,8'd14},      '{8'd8,8'd10,8'd12,8'd14},
    '{8'd8,8'd9,8'd11,8'd13},       '{8'd7,8'd9,8'd11,8'd12},
    '{8'd7,8'd9,8'd10,8'd12},       '{8'd7,8'd8,8'd10,8'd11},
    '{8'd6,8'd8,8'd9,8'd11},        '{8'd6,8'd7,8'd9,8'd10},
    '{8'd6,8'd7,8'd8,8'd9},         '{8'd2,8'd2,8'd2,8'd2}
  };

  localparam logic [ST_W-1:0] NEXT_LPS [64] = '{
    6'd0,6'd0,6'd1,6'd2,6'd2,6'd4,6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,6'd9,6'd11,6'd11,6'd12,
    6'd13,6'd13,6'd15,6'd15,6'd16,6'd16,6'd18,6'd18,6'd19,6'd19,6'd21,6'd21,6'd22,6'd22,
    6'd23,6'd24,6'd24,6'd25,6'd26,6'd26,6'd27,6'd27,6'd28,6'd29,6'd29,6'd30,6'd30,6'd30,
    6'd31,6'd32,6'd32,6'd33,6'd33,6'd33,6'd34,6'd34,6'd35,6'd35,6'd35,6'd36,6'd36,6'd36,
    6'd37,6'd37,6'd37,6'd38,6'd38,6'd63
  };

endpackage

// ===== hw/rtl/cabac_binary_arithmetic_encoder.sv =====
// Path: a regular bin reads context, updates the interval, renormalizes and pushes its last
//   run when done; terminate bins skip the context read, a set one adds three flush steps.
// Occupancy: a coding bin holds the back end, which takes commands only when idle, through
//   renormalizing, one shift per cycle unless stalled; context/coder loads retire in idle.
// Reset: coder low 0, range 510, outstanding count and overflow cleared, queue emptied;
//   the context memory is not cleared and must be loaded before use.
module cabac_binary_arithmetic_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic        bin_value_i,
  input  logic [9:0]  ctx_index_i,
  input  logic [5:0]  ctx_state_i,
  input  logic        ctx_mps_i,
  input  logic [9:0]  low_value_i,
  input  logic [8:0]  range_value_i,
  input  logic [15:0] outstanding_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        lead_bit_o,
  output logic [15:0] follow_count_o,
  output logic        overflow_o,
  output logic        last_o
);

  // Front end: classify each beat and queue it.
  cabac_pkg::item_t front_item, back_item;
  cabac_pkg::out_t  out_beat;
  logic front_push, fifo_full, fifo_valid, back_pop;

  cabac_front u_front (
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .command_i           (command_i),
    .bin_value_i         (bin_value_i),
    .ctx_index_i         (ctx_index_i),
    .ctx_state_i         (ctx_state_i),
    .ctx_mps_i           (ctx_mps_i),
    .low_value_i         (low_value_i),
    .range_value_i       (range_value_i),
    .outstanding_value_i (outstanding_value_i),
    .full_i              (fifo_full),
    .push_o              (front_push),
    .item_o              (front_item)
  );

  // Short queue decouples intake from the coding engine.
  cabac_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .item_i  (front_item),
    .full_o  (fifo_full),
    .pop_i   (back_pop),
    .valid_o (fifo_valid),
    .item_o  (back_item)
  );

  // Back end: context memory, interval update, renormalization and run output.
  cabac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (fifo_valid),
    .item_i      (back_item),
    .pop_o       (back_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_beat)
  );

  assign lead_bit_o     = out_beat.run.bit_v;
  assign follow_count_o = out_beat.run.follow;
  assign overflow_o     = out_beat.run.ov;
  assign last_o         = out_beat.last;

endmodule

// ===== hw/rtl/cabac_ram.sv =====
module cabac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cabac_front.sv =====
module cabac_front (
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                command_i,
  input  logic                      bin_value_i,
  input  logic [9:0]                ctx_index_i,
  input  logic [5:0]                ctx_state_i,
  input  logic                      ctx_mps_i,
  input  logic [9:0]                low_value_i,
  input  logic [8:0]                range_value_i,
  input  logic [15:0]               outstanding_value_i,
  input  logic                      full_i,
  output logic                      push_o,
  output cabac_pkg::item_t          item_o
);

  logic [32:0] outs_wide;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign outs_wide  = 33'(outstanding_value_i);

  // Classify: check the context index, clamp the loaded range, saturate the count.
  always_comb begin
    item_o.cmd      = cabac_pkg::cmd_e'(command_i);
    item_o.bin      = bin_value_i;
    item_o.idx_ok   = 11'(ctx_index_i) < 11'(cabac_pkg::NUM_CONTEXTS);
    item_o.idx      = ctx_index_i[cabac_pkg::CTX_AW-1:0];
    item_o.ctx      = {ctx_state_i, ctx_mps_i};
    item_o.low      = low_value_i;
    item_o.rng      = range_value_i[8] ? range_value_i : 9'd256;
    item_o.outs_sat = outs_wide > cabac_pkg::OUT_MAX_WIDE;
    item_o.outs     = item_o.outs_sat ? cabac_pkg::OUT_MAX
                                      : cabac_pkg::OUT_W'(outs_wide);
  end

endmodule

// ===== hw/rtl/cabac_fifo.sv =====
module cabac_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cabac_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output cabac_pkg::item_t item_o
);

  localparam int PW = (cabac_pkg::FIFO_DEPTH > 1) ? $clog2(cabac_pkg::FIFO_DEPTH) : 1;
  localparam int CW = $clog2(cabac_pkg::FIFO_DEPTH + 1);

  cabac_pkg::item_t mem_q [cabac_pkg::FIFO_DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == CW'(cabac_pkg::FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (32'(wptr_q) == cabac_pkg::FIFO_DEPTH - 1) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (32'(rptr_q) == cabac_pkg::FIFO_DEPTH - 1) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/cabac_back.sv =====
`include "cabac_binary_arithmetic_encoder_macros.svh"

module cabac_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  cabac_pkg::item_t               item_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cabac_pkg::out_t                out_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CODE   = 5'b00010,
    S_RENORM = 5'b00100,
    S_FLUSH  = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [10:0] low_q, low_d;
  logic [8:0]  rng_q, rng_d;
  logic [cabac_pkg::OUT_W-1:0] cnt_q, cnt_d;
  logic ovf_q, ovf_d;
  logic bin_q, bin_d, ok_q, ok_d, flush_q, flush_d;
  logic [cabac_pkg::CTX_AW-1:0] idx_q, idx_d;
  logic [1:0] step_q, step_d;
  logic pend_v_q, pend_v_d, out_v_q, out_v_d;
  cabac_pkg::run_t pend_q, pend_d;
  cabac_pkg::out_t out_q, out_d;

  logic ram_we, ram_re;
  logic [cabac_pkg::CTX_AW-1:0] ram_waddr, ram_raddr;
  logic [cabac_pkg::CTX_W-1:0]  ram_wdata, ram_rdata;

  logic can_push, push, push_last, prod, hold;
  cabac_pkg::run_t prod_run, put_run;
  logic [32:0] cnt_wide;
  logic [cabac_pkg::CTX_W-1:0] entry;
  logic [cabac_pkg::ST_W-1:0] st, st_n;
  logic mps, mps_n;
  logic [7:0] rlps;
  logic [8:0] rmps, r2;
  logic [10:0] low_sub;

  cabac_ram #(
    .WIDTH (cabac_pkg::CTX_W),
    .DEPTH (cabac_pkg::NUM_CONTEXTS)
  ) u_ctx_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign can_push    = !out_v_q || !out_stall_i;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // Run that releases the outstanding bits, clamped to the port width.
  assign cnt_wide           = 33'(cnt_q);
  assign put_run.follow     = (cnt_wide > cabac_pkg::FOLLOW_MAX) ? '1
                                                                 : cnt_wide[15:0];
  assign put_run.ov         = ovf_q || (cnt_wide > cabac_pkg::FOLLOW_MAX);
  assign put_run.bit_v      = 1'b0;

  assign entry = ok_q ? ram_rdata : '0;
  assign st    = entry[6:1];
  assign mps   = entry[0];
  assign rlps  = cabac_pkg::LPS_TAB[st][rng_q[7:6]];
  assign rmps  = rng_q - 9'(rlps);
  assign r2    = rng_q - 9'd2;

  always_comb begin
    state_d   = state_q;
    low_d     = low_q;
    rng_d     = rng_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    bin_d     = bin_q;
    ok_d      = ok_q;
    idx_d     = idx_q;
    flush_d   = flush_q;
    step_d    = step_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx_q;
    ram_raddr = item_i.idx;
    ram_wdata = item_i.ctx;
    push      = 1'b0;
    push_last = 1'b0;
    prod      = 1'b0;
    hold      = 1'b0;
    prod_run  = put_run;
    mps_n     = mps;
    st_n      = st;
    low_sub   = low_q;

    case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          case (item_i.cmd)
            cabac_pkg::CMD_REGULAR: begin
              ram_re  = 1'b1;
              bin_d   = item_i.bin;
              ok_d    = item_i.idx_ok;
              idx_d   = item_i.idx;
              state_d = S_CODE;
            end
            cabac_pkg::CMD_TERMINATE: begin
              flush_d = item_i.bin;
              step_d  = 2'd0;
              if (item_i.bin) begin
                low_d = low_q + 11'(r2);
                rng_d = 9'd2;
              end else begin
                rng_d = r2;
              end
              state_d = S_RENORM;
            end
            cabac_pkg::CMD_LOAD_CTX: begin
              ram_we    = item_i.idx_ok;
              ram_waddr = item_i.idx;
            end
            cabac_pkg::CMD_LOAD_CODER: begin
              low_d = {1'b0, item_i.low};
              rng_d = item_i.rng;
              cnt_d = item_i.outs;
              ovf_d = item_i.outs_sat;
            end
            default: ;
          endcase
        end
      end

      S_CODE: begin
        if (bin_q != mps) begin
          low_d = low_q + 11'(rmps);
          rng_d = 9'(rlps);
          mps_n = (st == '0) ? !mps : mps;
          st_n  = cabac_pkg::NEXT_LPS[st];
        end else begin
          rng_d = rmps;
          st_n  = (st < 6'd62) ? st + 1'b1 : st;
        end
        ram_we    = ok_q;
        ram_wdata = {st_n, mps_n};
        flush_d   = 1'b0;
        state_d   = S_RENORM;
      end

      S_RENORM: begin
        if (rng_q[8]) begin
          state_d = flush_q ? S_FLUSH : S_DONE;
        end else begin
          prod           = (low_q < 11'd256) || (low_q >= 11'd512);
          prod_run.bit_v = low_q >= 11'd512;
          hold           = prod && pend_v_q && !can_push;
          if (!hold) begin
            if (low_q >= 11'd512) begin
              low_sub = low_q - 11'd512;
            end else if (low_q >= 11'd256) begin
              low_sub = low_q - 11'd256;
              if (cnt_q == cabac_pkg::OUT_MAX) begin
                ovf_d = 1'b1;
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
            end
            if (prod) begin
              cnt_d = '0;
              ovf_d = 1'b0;
            end
            low_d = {1'b0, low_sub[8:0], 1'b0};
            rng_d = {rng_q[7:0], 1'b0};
          end
        end
      end

      S_FLUSH: begin
        prod = 1'b1;
        case (step_q)
          2'd0: begin
            prod_run.bit_v = low_q[9];
          end
          2'd1: begin
            prod_run = '{bit_v: low_q[8], follow: '0, ov: 1'b0};
          end
          default: begin
            prod_run = '{bit_v: 1'b1, follow: '0, ov: 1'b0};
          end
        endcase
        if (!(pend_v_q && !can_push)) begin
          if (step_q == 2'd0) begin
            cnt_d = '0;
            ovf_d = 1'b0;
          end
          step_d = step_q + 1'b1;
          if (step_q == 2'd2) begin
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (can_push) begin
          push      = 1'b1;
          push_last = 1'b1;
          pend_v_d  = 1'b0;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Hand the held run on once a newer one proves it was not the last.
    if (prod && !(pend_v_q && !can_push)) begin
      push     = pend_v_q;
      pend_d   = prod_run;
      pend_v_d = 1'b1;
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
    if (push) begin
      out_v_d = 1'b1;
      out_d   = '{run: pend_q, last: push_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      low_q    <= '0;
      rng_q    <= 9'd510;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      flush_q  <= 1'b0;
      step_q   <= '0;
    end else begin
      state_q  <= state_d;
      low_q    <= low_d;
      rng_q    <= rng_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      flush_q  <= flush_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    ok_q   <= ok_d;
    idx_q  <= idx_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  `CABAC_ASSERT(a_done_range_norm, state_q == S_DONE |-> rng_q[8], "range not normalized at end")
  `CABAC_NEVER(a_idle_pending, state_q == S_IDLE && pend_v_q, "run still held when idle")
  `CABAC_ASSERT(a_low_width, (state_q == S_IDLE || state_q == S_DONE) |-> !low_q[10],
                "low carry left after renormalization")

endmodule
